// ===== design/nested_conditional_section_tracker_core_defines.svh =====
// assertion macros shared by the section tracker rtl
`ifndef NESTED_CONDITIONAL_SECTION_TRACKER_CORE_DEFINES_SVH
`define NESTED_CONDITIONAL_SECTION_TRACKER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// expression must hold at every edge outside reset
`define NCT_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("section tracker check failed");

// consequent must hold in the same cycle as the antecedent
`define NCT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("section tracker check failed");

// consequent must hold in the cycle after the antecedent
`define NCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("section tracker check failed");

`else

`define NCT_ASSERT_ALWAYS(label, clk, rst, expr)
`define NCT_ASSERT_SAME(label, clk, rst, ante, cons)
`define NCT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/nct_pkg.sv =====
// types and constants of the nested conditional section tracker
`default_nettype none

package nct_pkg;

   localparam int MAX_NESTING_DEFAULT = 16;
   localparam int DEPTH_WIDTH = 5;

   typedef enum logic [2:0] {
      CMD_BLANK = 3'd0,
      CMD_IF    = 3'd1,
      CMD_ELSIF = 3'd2,
      CMD_ELSE  = 3'd3,
      CMD_ENDIF = 3'd4,
      CMD_LINE  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      SEC_EXEC      = 2'd0,
      SEC_IGNORE    = 2'd1,
      SEC_TIL_ENDIF = 2'd2
   } sec_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NO_COND   = 3'd1,
      ST_ELSIF_OUT = 3'd2,
      ST_ELSE_OUT  = 3'd3,
      ST_ENDIF_OUT = 3'd4,
      ST_OVERFLOW  = 3'd5,
      ST_BARE      = 3'd6
   } status_type;

   typedef struct packed {
      cmd_type cmd;
      logic    has_condition;
      logic    negate_parity;
      logic    bare_negation;
      logic    cond_ok;
   } req_type;

   typedef struct packed {
      logic                   run_line;
      logic                   eval_condition;
      status_type             status;
      logic [DEPTH_WIDTH-1:0] nest_depth;
   } rsp_type;

   typedef struct packed {
      logic    push;
      logic    set_top;
      logic    pop;
      sec_type value;
   } stack_op_type;

endpackage

`default_nettype wire

// ===== design/nct_stack.sv =====
// section stack: memory of entries with the top entry held in a register
`default_nettype none
`include "nested_conditional_section_tracker_core_defines.svh"

module nct_stack #(
   parameter int MAX_NESTING = nct_pkg::MAX_NESTING_DEFAULT,
   localparam int CountWidth = $clog2(MAX_NESTING + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  nct_pkg::stack_op_type op,
   output logic [CountWidth-1:0] stack_count,
   output logic [CountWidth-1:0] stack_count_next,
   output nct_pkg::sec_type      top_state
);
   import nct_pkg::*;

   localparam int AddrWidth = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;

   sec_type mem [MAX_NESTING];

   logic [CountWidth-1:0] count_ff, count_in;
   sec_type               top_ff, top_in;
   sec_type               below_ff;
   logic [CountWidth-1:0] wr_idx, rd_idx;

   always_comb begin
      count_in = count_ff;
      if (op.push) begin
         count_in = count_ff + CountWidth'(1);
      end else if (op.pop) begin
         count_in = count_ff - CountWidth'(1);
      end
   end

   // the entry under the top is fetched into a register ahead of time so a pop finds it ready
   always_comb begin
      top_in = top_ff;
      if (op.push || op.set_top) begin
         top_in = op.value;
      end else if (op.pop) begin
         top_in = below_ff;
      end
   end

   assign wr_idx = count_in - CountWidth'(1);
   assign rd_idx = count_in - CountWidth'(2);

   always_ff @(posedge clock) begin
      if (op.push || op.set_top) begin
         mem[wr_idx[AddrWidth-1:0]] <= op.value;
      end
      below_ff <= mem[rd_idx[AddrWidth-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      top_ff <= top_in;
   end

   assign stack_count      = count_ff;
   assign stack_count_next = count_in;
   assign top_state        = top_ff;

   `NCT_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CountWidth'(MAX_NESTING))
   `NCT_ASSERT_ALWAYS(a_single_op, clock, reset, !(op.push && op.pop))
   `NCT_ASSERT_NEXT(a_push_grows, clock, reset, op.push, count_ff == $past(count_ff) + CountWidth'(1))
   `NCT_ASSERT_NEXT(a_pop_shrinks, clock, reset, op.pop, count_ff == $past(count_ff) - CountWidth'(1))

endmodule

`default_nettype wire

// ===== design/nested_conditional_section_tracker_core.sv =====
// top level of the nested conditional section tracker
// channel  direction  handshake              payload
// req      in         req_valid / req_stall   nct_pkg::req_type
// rsp      out        rsp_valid / rsp_stall   nct_pkg::rsp_type
// one item per cycle while req_stall is low; each result appears in the cycle after its transfer
// the stack top sits in a register and the entry below it is read from the
// stack memory into a register ahead of time, so a pop never stalls requests
// reset clears the depth count and the result valid flag; no clearing pass
// req_stall follows a held result that the rsp side stalls
`default_nettype none
`include "nested_conditional_section_tracker_core_defines.svh"

module nested_conditional_section_tracker_core #(
   parameter int MAX_NESTING = nct_pkg::MAX_NESTING_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  nct_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output nct_pkg::rsp_type rsp_data
);
   import nct_pkg::*;

   localparam int CountWidth = $clog2(MAX_NESTING + 1);

   logic                  accept;
   logic                  open, full, truth;
   stack_op_type          op;
   logic [CountWidth-1:0] stack_count, stack_count_next;
   sec_type               top_state;
   logic [CountWidth+DEPTH_WIDTH-1:0] depth_wide;

   logic    run, eval;
   status_type status;
   rsp_type rsp_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign open  = stack_count != '0;
   assign full  = stack_count == CountWidth'(MAX_NESTING);
   assign truth = ~req_data.bare_negation & (req_data.cond_ok ^ req_data.negate_parity);

   always_comb begin
      op     = '{push: 1'b0, set_top: 1'b0, pop: 1'b0, value: SEC_EXEC};
      run    = 1'b0;
      eval   = 1'b0;
      status = ST_OK;
      unique case (req_data.cmd)
         CMD_IF: begin
            if (open && top_state != SEC_EXEC) begin
               if (full) begin
                  status = ST_OVERFLOW;
               end else begin
                  op.push  = 1'b1;
                  op.value = SEC_TIL_ENDIF;
               end
            end else if (!req_data.has_condition) begin
               status = ST_NO_COND;
            end else if (full) begin
               status = ST_OVERFLOW;
            end else begin
               status   = req_data.bare_negation ? ST_BARE : ST_OK;
               eval     = ~req_data.bare_negation;
               op.push  = 1'b1;
               op.value = truth ? SEC_EXEC : SEC_IGNORE;
            end
         end
         CMD_ELSIF: begin
            if (!open) begin
               status = ST_ELSIF_OUT;
            end else if (top_state == SEC_EXEC) begin
               op.set_top = 1'b1;
               op.value   = SEC_TIL_ENDIF;
            end else if (top_state == SEC_IGNORE) begin
               if (!req_data.has_condition) begin
                  status = ST_NO_COND;
               end else begin
                  status     = req_data.bare_negation ? ST_BARE : ST_OK;
                  eval       = ~req_data.bare_negation;
                  op.set_top = truth;
                  op.value   = SEC_EXEC;
               end
            end
         end
         CMD_ELSE: begin
            if (!open) begin
               status = ST_ELSE_OUT;
            end else if (top_state == SEC_EXEC) begin
               op.set_top = 1'b1;
               op.value   = SEC_TIL_ENDIF;
            end else if (top_state == SEC_IGNORE) begin
               op.set_top = 1'b1;
               op.value   = SEC_EXEC;
            end
         end
         CMD_ENDIF: begin
            if (!open) begin
               status = ST_ENDIF_OUT;
            end else begin
               op.pop = 1'b1;
            end
         end
         CMD_LINE: begin
            run = ~open | (top_state == SEC_EXEC);
         end
         default: begin
         end
      endcase
      // nothing touches the stack without a transfer
      op.push    = op.push & accept;
      op.set_top = op.set_top & accept;
      op.pop     = op.pop & accept;
   end

   nct_stack #(
      .MAX_NESTING(MAX_NESTING)
   ) u_stack (
      .clock           (clock),
      .reset           (reset),
      .op              (op),
      .stack_count     (stack_count),
      .stack_count_next(stack_count_next),
      .top_state       (top_state)
   );

   assign depth_wide = {{DEPTH_WIDTH{1'b0}}, stack_count_next};

   always_comb begin
      rsp_in.run_line       = run;
      rsp_in.eval_condition = eval;
      rsp_in.status         = status;
      rsp_in.nest_depth     = depth_wide[DEPTH_WIDTH-1:0];
   end

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `NCT_ASSERT_NEXT(a_accept_gives_result, clock, reset, accept, rsp_valid_ff)
   `NCT_ASSERT_SAME(a_run_is_clean, clock, reset, rsp_valid_ff && rsp_data_ff.run_line, rsp_data_ff.status == ST_OK && !rsp_data_ff.eval_condition)
   `NCT_ASSERT_SAME(a_pop_needs_open, clock, reset, op.pop, stack_count != '0)

endmodule

`default_nettype wire

// ===== verif/tb_nested_conditional_section_tracker_core.sv =====
// self-checking testbench of the nested conditional section tracker core
`default_nettype none

module tb_nested_conditional_section_tracker_core;
   import nct_pkg::*;

   localparam int NEST_LIMIT    = nct_pkg::MAX_NESTING_DEFAULT;
   localparam int RANDOM_LINES  = 1300;
   localparam int QUIET_LINES   = 150;
   localparam int PHASE_LINES   = 100;
   localparam int LONG_HOLD     = 60;
   localparam int MAX_REPORTS   = 10;

   typedef enum int {
      MIX_BALANCED = 0,
      MIX_DEEP     = 1,
      MIX_DRAIN    = 2
   } mix_type;

   // mirror of the section stack; predicts one result per transfer
   class section_scoreboard;
      sec_type     sections[NEST_LIMIT];
      int unsigned open_count;
      rsp_type     predicted_results[$];
      int unsigned mismatches;
      int unsigned lines_seen;
      int unsigned results_seen;
      int unsigned status_hits[8];
      int unsigned deepest;

      function new();
         open_count   = 0;
         mismatches   = 0;
         lines_seen   = 0;
         results_seen = 0;
         deepest      = 0;
         foreach (status_hits[i]) status_hits[i] = 0;
      endfunction

      function void note_request(req_type r);
         logic       truth;
         logic       open;
         sec_type    top;
         rsp_type    res;
         status_type st;
         truth = !r.bare_negation && (r.cond_ok != r.negate_parity);
         open  = (open_count != 0);
         top   = open ? sections[open_count-1] : SEC_TIL_ENDIF;
         res   = '0;
         st    = ST_OK;
         case (r.cmd)
            CMD_IF: begin
               if (open && top != SEC_EXEC) begin
                  // nested inside a dead section: condition is never looked at
                  if (open_count >= NEST_LIMIT) st = ST_OVERFLOW;
                  else begin
                     sections[open_count] = SEC_TIL_ENDIF;
                     open_count++;
                  end
               end else if (!r.has_condition) begin
                  st = ST_NO_COND;
               end else if (open_count >= NEST_LIMIT) begin
                  st = ST_OVERFLOW;
               end else begin
                  if (r.bare_negation) st = ST_BARE;
                  else res.eval_condition = 1'b1;
                  sections[open_count] = truth ? SEC_EXEC : SEC_IGNORE;
                  open_count++;
               end
            end
            CMD_ELSIF: begin
               if (!open) st = ST_ELSIF_OUT;
               else if (top == SEC_EXEC) sections[open_count-1] = SEC_TIL_ENDIF;
               else if (top == SEC_IGNORE) begin
                  if (!r.has_condition) st = ST_NO_COND;
                  else begin
                     if (r.bare_negation) st = ST_BARE;
                     else res.eval_condition = 1'b1;
                     if (truth) sections[open_count-1] = SEC_EXEC;
                  end
               end
            end
            CMD_ELSE: begin
               if (!open) st = ST_ELSE_OUT;
               else if (top == SEC_EXEC) sections[open_count-1] = SEC_TIL_ENDIF;
               else if (top == SEC_IGNORE) sections[open_count-1] = SEC_EXEC;
            end
            CMD_ENDIF: begin
               if (!open) st = ST_ENDIF_OUT;
               else open_count--;
            end
            CMD_LINE: begin
               res.run_line = !open || top == SEC_EXEC;
            end
            default: begin
            end
         endcase
         res.status     = st;
         res.nest_depth = open_count[DEPTH_WIDTH-1:0];
         status_hits[st]++;
         if (open_count > deepest) deepest = open_count;
         lines_seen++;
         predicted_results.push_back(res);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         results_seen++;
         if (predicted_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result: run=%0b eval=%0b status=%0d depth=%0d",
                        got.run_line, got.eval_condition, got.status, got.nest_depth);
            return;
         end
         want = predicted_results.pop_front();
         if (got.run_line !== want.run_line || got.eval_condition !== want.eval_condition ||
             got.status !== want.status || got.nest_depth !== want.nest_depth) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("result %0d mismatch: expected run=%0b eval=%0b status=%0d depth=%0d,%s",
                        results_seen, want.run_line, want.eval_condition, want.status,
                        want.nest_depth, "");
            if (mismatches <= MAX_REPORTS)
               $display("   got run=%0b eval=%0b status=%0d depth=%0d",
                        got.run_line, got.eval_condition, got.status, got.nest_depth);
         end
      endfunction

      function int outstanding();
         return predicted_results.size();
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   section_scoreboard sb = new();
   bit quiet            = 1'b0;
   bit long_hold_wanted = 1'b0;
   bit long_hold_done   = 1'b0;

   nested_conditional_section_tracker_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   function automatic req_type make_req(cmd_type c, bit has, bit neg, bit bare, bit ok);
      req_type r;
      r.cmd           = c;
      r.has_condition = has;
      r.negate_parity = neg;
      r.bare_negation = bare;
      r.cond_ok       = ok;
      return r;
   endfunction

   function automatic req_type random_line(mix_type mix);
      int unsigned limits[7];
      int unsigned pick;
      int          slot;
      cmd_type     c;
      // order: if, elsif, else, endif, line, blank, unused code
      case (mix)
         MIX_DEEP:  limits = '{45, 55, 63, 71, 92, 97, 100};
         MIX_DRAIN: limits = '{10, 20, 28, 68, 90, 96, 100};
         default:   limits = '{24, 36, 46, 66, 90, 96, 100};
      endcase
      pick = $urandom_range(0, 99);
      slot = 0;
      while (pick >= limits[slot]) slot++;
      case (slot)
         0: c = CMD_IF;
         1: c = CMD_ELSIF;
         2: c = CMD_ELSE;
         3: c = CMD_ENDIF;
         4: c = CMD_LINE;
         5: c = CMD_BLANK;
         default: c = cmd_type'(3'($urandom_range(6, 7)));
      endcase
      return make_req(c, $urandom_range(0, 11) != 0, 1'($urandom_range(0, 1)),
                      $urandom_range(0, 11) == 0, 1'($urandom_range(0, 1)));
   endfunction

   // one transfer on the request side; called right after a falling edge
   task automatic send_line(req_type r);
      int gap;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
   endtask

   // result side stall pattern
   initial begin
      forever begin
         @(negedge clock);
         if (long_hold_wanted) begin
            long_hold_wanted = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            rsp_stall <= 1'b0;
            long_hold_done = 1'b1;
         end else if (!quiet && !reset && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   initial begin
      #2000000;
      $display("timeout waiting for results");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      mix_type mix;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: outside keywords, unused codes, and each branch kind
      send_line(make_req(CMD_BLANK, 1, 1, 1, 1));
      send_line(make_req(CMD_LINE,  0, 0, 0, 0));
      send_line(make_req(CMD_ELSIF, 1, 0, 0, 1));
      send_line(make_req(CMD_ELSE,  0, 0, 0, 0));
      send_line(make_req(CMD_ENDIF, 0, 0, 0, 0));
      send_line(make_req(cmd_type'(3'd6), 1, 1, 1, 1));
      send_line(make_req(cmd_type'(3'd7), 1, 1, 1, 1));
      send_line(make_req(CMD_IF,    0, 0, 0, 1));
      send_line(make_req(CMD_IF,    1, 1, 1, 1));   // bare negation pushes ignore
      send_line(make_req(CMD_LINE,  0, 0, 0, 0));
      send_line(make_req(CMD_ELSIF, 0, 0, 0, 1));
      send_line(make_req(CMD_ELSIF, 1, 0, 1, 1));
      send_line(make_req(CMD_ELSIF, 1, 0, 0, 1));
      send_line(make_req(CMD_LINE,  0, 0, 0, 0));
      send_line(make_req(CMD_ELSIF, 1, 0, 0, 1));
      send_line(make_req(CMD_LINE,  0, 0, 0, 0));
      send_line(make_req(CMD_IF,    0, 0, 0, 0));   // dead section ignores condition
      send_line(make_req(CMD_ELSE,  0, 0, 0, 0));
      send_line(make_req(CMD_ENDIF, 0, 0, 0, 0));
      send_line(make_req(CMD_ELSE,  0, 0, 0, 0));
      send_line(make_req(CMD_ENDIF, 0, 0, 0, 0));
      send_line(make_req(CMD_IF,    1, 1, 0, 1));   // negated true is false
      send_line(make_req(CMD_ELSE,  0, 0, 0, 0));
      send_line(make_req(CMD_LINE,  0, 0, 0, 0));
      send_line(make_req(CMD_ENDIF, 0, 0, 0, 0));
      drain_results();
      @(negedge clock);

      mix = MIX_DEEP;
      for (int i = 0; i < RANDOM_LINES; i++) begin
         if (i % PHASE_LINES == 0 && i != 0)
            mix = mix_type'($urandom_range(0, 2));
         if (i == 300 || i == 800) long_hold_wanted = 1'b1;
         if (i == 600) begin
            drain_results();
            @(negedge clock);
         end
         if (i == RANDOM_LINES - QUIET_LINES) quiet = 1'b1;
         send_line(random_line(mix));
      end
      req_valid <= 1'b0;

      while (sb.outstanding() != 0) @(negedge clock);
      repeat (5) @(negedge clock);
      $display("%0d lines sent, %0d results checked, nesting reached %0d",
               sb.lines_seen, sb.results_seen, sb.deepest);
      $display("overflows %0d, bare negations %0d, missing conditions %0d, long hold %0s",
               sb.status_hits[ST_OVERFLOW], sb.status_hits[ST_BARE],
               sb.status_hits[ST_NO_COND], long_hold_done ? "done" : "missed");
      if (sb.mismatches == 0 && sb.outstanding() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+design
design/nct_pkg.sv
design/nct_stack.sv
design/nested_conditional_section_tracker_core.sv
verif/tb_nested_conditional_section_tracker_core.sv
